/* hdl/fvbs_pkg.sv */
`timescale 1ns / 1ps
package fvbs_pkg;
	localparam int MAX_BITS = 4096;
	localparam int CNT_W    = 13;
	localparam int WGT_W    = 12;
	localparam int WSUM_W   = 13;
	localparam int SIM_W    = 17;
	localparam int STAT_W   = 2;
	localparam int IDX_W    = 2;
	localparam int QUO_W    = 17;
	localparam int DEN_W    = 53;
	localparam int NUM_W    = 56;

	localparam logic [IDX_W-1:0] REG_ON_WEIGHT  = 2'd0;
	localparam logic [IDX_W-1:0] REG_OFF_WEIGHT = 2'd1;

	localparam logic [STAT_W-1:0] ST_OK  = 2'd0;
	localparam logic [STAT_W-1:0] ST_SAT = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD = 2'd2;

	localparam logic [SIM_W-1:0] SIM_ONE  = 17'h10000;
	localparam logic [SIM_W-1:0] SIM_ZERO = 17'h00000;

	localparam logic [WGT_W-1:0]  ON_WEIGHT_RST  = 12'd512;
	localparam logic [WGT_W-1:0]  OFF_WEIGHT_RST = 12'd256;
	localparam logic [WSUM_W-1:0] WSUM_RST       = 13'd768;
endpackage

/* hdl/fvb_fingerprint_similarity.sv */
`timescale 1ns / 1ps
// Result strobe (done) is registered behind stages s1 to s5 and the divider stages.
// Throughput: one transaction per cycle; busy stays low, as five arithmetic
// stages and a 17-stage restoring divider (one quotient bit a stage) all advance every cycle.
// The receiver cannot stall: every result shows for exactly one cycle.
// Reset (arst_n low, asynchronous) clears all valid bits and restores the weights.
module fvb_fingerprint_similarity (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [fvbs_pkg::CNT_W-1:0]    bit_length,
	input  logic [fvbs_pkg::CNT_W-1:0]    set_count_a,
	input  logic [fvbs_pkg::CNT_W-1:0]    set_count_b,
	input  logic [fvbs_pkg::CNT_W-1:0]    both_clear_count,
	input  logic [fvbs_pkg::CNT_W-1:0]    both_set_count,
	input  logic                          cfg_we,
	input  logic [fvbs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [fvbs_pkg::WGT_W-1:0]    cfg_data,
	output logic                          done,
	output logic [fvbs_pkg::SIM_W-1:0]    similarity,
	output logic [fvbs_pkg::STAT_W-1:0]   status
);
	import fvbs_pkg::*;

	// configuration
	logic [WGT_W-1:0]  w1_q, w0_q;
	logic [WSUM_W-1:0] wsum_q;

	// stage 1: differences and special cases
	logic              v_s1, fix_s1;
	logic [SIM_W-1:0]  fsim_s1;
	logic [STAT_W-1:0] fst_s1;
	logic [13:0]       len2_s1, sum_s1;
	logic [CNT_W-1:0]  d0_s1, d1_s1, n11_s1, n00_s1;
	logic [WGT_W-1:0]  w1_s1, w0_s1;
	logic [WSUM_W-1:0] ws_s1;

	// stage 2: first products
	logic              v_s2, fix_s2;
	logic [SIM_W-1:0]  fsim_s2;
	logic [STAT_W-1:0] fst_s2;
	logic signed [27:0] a_s2;
	logic [26:0]       b_s2, l1_s2;
	logic [25:0]       p1_s2, p0_s2;
	logic [CNT_W-1:0]  d0_s2;
	logic [WSUM_W-1:0] ws_s2;

	// stage 3: second products
	logic              v_s3, fix_s3;
	logic [SIM_W-1:0]  fsim_s3;
	logic [STAT_W-1:0] fst_s3;
	logic signed [54:0] x_s3;
	logic [52:0]       y_s3;
	logic [39:0]       l2_s3;
	logic [WSUM_W-1:0] ws_s3;

	// stage 4: numerator and denominator
	logic              v_s4, fix_s4;
	logic [SIM_W-1:0]  fsim_s4;
	logic [STAT_W-1:0] fst_s4;
	logic signed [NUM_W-1:0] num_s4;
	logic [DEN_W-1:0]  den_s4;

	// stage 5: range checks
	logic              v_s5, fix_s5;
	logic [SIM_W-1:0]  fsim_s5;
	logic [STAT_W-1:0] fst_s5;
	logic [DEN_W-1:0]  rem_s5, den_s5;

	// divider stages
	logic              v_sd    [0:QUO_W];
	logic              fix_sd  [0:QUO_W];
	logic [SIM_W-1:0]  fsim_sd [0:QUO_W];
	logic [STAT_W-1:0] fst_sd  [0:QUO_W];
	logic [DEN_W-1:0]  rem_sd  [0:QUO_W];
	logic [DEN_W-1:0]  den_sd  [0:QUO_W];
	logic [QUO_W-1:0]  q_sd    [0:QUO_W];

	logic              acc;
	logic              bad, one;
	logic [QUO_W:0]    q_inc;

	assign busy = 1'b0;
	assign acc  = start & ~busy;

	// hold the weights and their sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_q   <= ON_WEIGHT_RST;
			w0_q   <= OFF_WEIGHT_RST;
			wsum_q <= WSUM_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_ON_WEIGHT) begin
				w1_q   <= cfg_data;
				wsum_q <= {1'b0, cfg_data} + {1'b0, w0_q};
			end else if (cfg_index == REG_OFF_WEIGHT) begin
				w0_q   <= cfg_data;
				wsum_q <= {1'b0, w1_q} + {1'b0, cfg_data};
			end
		end
	end

	// classify the pair
	assign bad = (bit_length > CNT_W'(MAX_BITS)) || (set_count_a > bit_length) ||
		(set_count_b > bit_length) || (both_clear_count > bit_length) ||
		(both_set_count > bit_length);
	assign one = (both_set_count == bit_length) || (both_clear_count == bit_length);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			done <= v_sd[QUO_W];
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		len2_s1 <= {bit_length, 1'b0};
		sum_s1  <= {1'b0, set_count_a} + {1'b0, set_count_b};
		d0_s1   <= bit_length - both_set_count;
		d1_s1   <= bit_length - both_clear_count;
		n11_s1  <= both_set_count;
		n00_s1  <= both_clear_count;
		w1_s1   <= w1_q;
		w0_s1   <= w0_q;
		ws_s1   <= wsum_q;
		fix_s1  <= bad | one | (wsum_q == '0);
		if (bad) begin
			fsim_s1 <= SIM_ZERO;
			fst_s1  <= ST_BAD;
		end else if (one) begin
			fsim_s1 <= SIM_ONE;
			fst_s1  <= ST_OK;
		end else begin
			fsim_s1 <= SIM_ZERO;
			fst_s1  <= ST_SAT;
		end
	end

	// stage 2: weight terms and count products
	always_ff @(posedge clk) begin
		a_s2    <= $signed({2'b00, 26'(w1_s1 * len2_s1)}) - $signed({6'b0, sum_s1, 8'b0});
		b_s2    <= 27'(w0_s1 * len2_s1) + {5'b0, sum_s1, 8'b0};
		p1_s2   <= 26'(n11_s1 * d0_s1);
		p0_s2   <= 26'(n00_s1 * d1_s1);
		l1_s2   <= 27'(len2_s1 * d1_s1);
		d0_s2   <= d0_s1;
		ws_s2   <= ws_s1;
		fix_s2  <= fix_s1;
		fsim_s2 <= fsim_s1;
		fst_s2  <= fst_s1;
	end

	// stage 3: weighted terms and partial denominator
	always_ff @(posedge clk) begin
		x_s3    <= a_s2 * $signed({1'b0, p1_s2});
		y_s3    <= 53'(b_s2 * p0_s2);
		l2_s3   <= 40'(l1_s2 * d0_s2);
		ws_s3   <= ws_s2;
		fix_s3  <= fix_s2;
		fsim_s3 <= fsim_s2;
		fst_s3  <= fst_s2;
	end

	// stage 4: full fraction
	always_ff @(posedge clk) begin
		num_s4  <= NUM_W'(x_s3) + $signed({3'b0, y_s3});
		den_s4  <= DEN_W'(l2_s3 * ws_s3);
		fix_s4  <= fix_s3;
		fsim_s4 <= fsim_s3;
		fst_s4  <= fst_s3;
	end

	// stage 5: saturate out-of-range blends
	always_ff @(posedge clk) begin
		rem_s5 <= num_s4[DEN_W-1:0];
		den_s5 <= den_s4;
		if (fix_s4) begin
			fix_s5  <= 1'b1;
			fsim_s5 <= fsim_s4;
			fst_s5  <= fst_s4;
		end else if (num_s4 < 0) begin
			fix_s5  <= 1'b1;
			fsim_s5 <= SIM_ZERO;
			fst_s5  <= ST_SAT;
		end else if (num_s4 > $signed({3'b0, den_s4})) begin
			fix_s5  <= 1'b1;
			fsim_s5 <= SIM_ONE;
			fst_s5  <= ST_SAT;
		end else if (num_s4 == $signed({3'b0, den_s4})) begin
			fix_s5  <= 1'b1;
			fsim_s5 <= SIM_ONE;
			fst_s5  <= ST_OK;
		end else begin
			fix_s5  <= 1'b0;
			fsim_s5 <= fsim_s4;
			fst_s5  <= ST_OK;
		end
	end

	// feed the divider
	assign v_sd[0]    = v_s5;
	assign fix_sd[0]  = fix_s5;
	assign fsim_sd[0] = fsim_s5;
	assign fst_sd[0]  = fst_s5;
	assign rem_sd[0]  = rem_s5;
	assign den_sd[0]  = den_s5;
	assign q_sd[0]    = '0;

	// one quotient bit per stage
	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		logic [DEN_W:0] shl;
		logic           ge;

		assign shl = {rem_sd[i], 1'b0};
		assign ge  = shl >= {1'b0, den_sd[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[i+1] <= 1'b0;
			end else begin
				v_sd[i+1] <= v_sd[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_sd[i+1]  <= ge ? DEN_W'(shl - {1'b0, den_sd[i]}) : DEN_W'(shl);
			q_sd[i+1]    <= {q_sd[i][QUO_W-2:0], ge};
			den_sd[i+1]  <= den_sd[i];
			fix_sd[i+1]  <= fix_sd[i];
			fsim_sd[i+1] <= fsim_sd[i];
			fst_sd[i+1]  <= fst_sd[i];
		end
	end

	// round half up and drive the result
	assign q_inc = {1'b0, q_sd[QUO_W]} + 1'b1;

	always_ff @(posedge clk) begin
		if (fix_sd[QUO_W]) begin
			similarity <= fsim_sd[QUO_W];
		end else begin
			similarity <= q_inc[QUO_W:1];
		end
		status <= fst_sd[QUO_W];
	end

`ifndef ASSERT_OFF
	a_no_reserved_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_SAT || status == ST_BAD))
		else $error("reserved status code on result");
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_BAD |-> similarity == SIM_ZERO)
		else $error("bad-count result carries a nonzero similarity");
	a_sim_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> similarity <= SIM_ONE)
		else $error("similarity above 1.0");
	a_done_follows_s5: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> ##(QUO_W + 1) done)
		else $error("divider lost a transaction");
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");
`endif
endmodule

/* tb/fvbs_checker.sv */
`timescale 1ns / 1ps
module fvbs_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [fvbs_pkg::CNT_W-1:0]    bit_length,
	input  logic [fvbs_pkg::CNT_W-1:0]    set_count_a,
	input  logic [fvbs_pkg::CNT_W-1:0]    set_count_b,
	input  logic [fvbs_pkg::CNT_W-1:0]    both_clear_count,
	input  logic [fvbs_pkg::CNT_W-1:0]    both_set_count,
	input  logic                          cfg_we,
	input  logic [fvbs_pkg::IDX_W-1:0]    cfg_index,
	input  logic [fvbs_pkg::WGT_W-1:0]    cfg_data,
	input  logic                          done,
	input  logic [fvbs_pkg::SIM_W-1:0]    similarity,
	input  logic [fvbs_pkg::STAT_W-1:0]   status,
	output int                            fail_count,
	output int                            pending
);
	import fvbs_pkg::*;

	typedef struct packed {
		logic [SIM_W-1:0]  sim;
		logic [STAT_W-1:0] st;
	} score_t;

	logic [WGT_W-1:0]  w_on, w_off;
	logic [WSUM_W-1:0] w_sum;
	score_t            score_q[$];

	assign pending = score_q.size();

	function automatic score_t score_pair(input logic [CNT_W-1:0] nb, sa, sb, n00, n11);
		score_t        s;
		longint        len2, tot, d0, d1, num, den;
		longint unsigned r, d, q;
		s.sim = SIM_ZERO;
		s.st  = ST_OK;
		if (nb > MAX_BITS || sa > nb || sb > nb || n00 > nb || n11 > nb) begin
			s.st = ST_BAD;
			return s;
		end
		if (n11 == nb || n00 == nb) begin
			s.sim = SIM_ONE;
			return s;
		end
		if (w_sum == 0) begin
			s.st = ST_SAT;
			return s;
		end
		len2 = 2 * longint'(nb);
		tot  = longint'(sa) + longint'(sb);
		d0   = longint'(nb) - longint'(n11);
		d1   = longint'(nb) - longint'(n00);
		num  = (longint'(w_on) * len2 - 256 * tot) * longint'(n11) * d0
			+ (longint'(w_off) * len2 + 256 * tot) * longint'(n00) * d1;
		den  = len2 * d1 * d0 * longint'(w_sum);
		if (num < 0) begin
			s.st = ST_SAT;
		end else if (num > den) begin
			s.sim = SIM_ONE;
			s.st  = ST_SAT;
		end else if (num == den) begin
			s.sim = SIM_ONE;
		end else begin
			// long division for 17 fractional bits, then round half up
			r = num;
			d = den;
			q = 0;
			for (int i = 0; i < QUO_W; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= d) begin
					r = r - d;
					q = q | 1;
				end
			end
			s.sim = SIM_W'((q + 1) >> 1);
		end
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// track weights, queue scores on accepted transactions, compare on done
	always @(posedge clk or negedge arst_n) begin
		score_t want;
		if (!arst_n) begin
			w_on  <= ON_WEIGHT_RST;
			w_off <= OFF_WEIGHT_RST;
			w_sum <= WSUM_RST;
			score_q.delete();
		end else begin
			if (done) begin
				if (score_q.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = score_q.pop_front();
					if (similarity !== want.sim)
						report_mismatch($sformatf("similarity %0d, wanted %0d",
							similarity, want.sim));
					if (status !== want.st)
						report_mismatch($sformatf("status %0d, wanted %0d", status, want.st));
				end
			end
			if (start && !busy)
				score_q.push_back(score_pair(bit_length, set_count_a, set_count_b,
					both_clear_count, both_set_count));
			if (cfg_we) begin
				if (cfg_index == REG_ON_WEIGHT) begin
					w_on  <= cfg_data;
					w_sum <= WSUM_W'(cfg_data) + WSUM_W'(w_off);
				end else if (cfg_index == REG_OFF_WEIGHT) begin
					w_off <= cfg_data;
					w_sum <= WSUM_W'(w_on) + WSUM_W'(cfg_data);
				end
			end
		end
	end
endmodule

/* tb/tb_fvb_fingerprint_similarity.sv */
`timescale 1ns / 1ps
module tb_fvb_fingerprint_similarity;
	import fvbs_pkg::*;

	localparam int WATCHDOG = 2000;
	localparam int DRAIN    = 40;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [CNT_W-1:0]   bit_length = '0, set_count_a = '0, set_count_b = '0;
	logic [CNT_W-1:0]   both_clear_count = '0, both_set_count = '0;
	logic               cfg_we = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [WGT_W-1:0]   cfg_data = '0;
	logic               done;
	logic [SIM_W-1:0]   similarity;
	logic [STAT_W-1:0]  status;
	int                 fail_count, pending;
	int                 quiet_cycles = 0;
	int                 idle_pct = 0;

	always #5 clk = ~clk;

	fvb_fingerprint_similarity dut (.*);
	fvbs_checker u_checker (.*);

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_pair(input logic [CNT_W-1:0] nb, sa, sb, n00, n11);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start            <= 1'b1;
		bit_length       <= nb;
		set_count_a      <= sa;
		set_count_b      <= sb;
		both_clear_count <= n00;
		both_set_count   <= n11;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic settle;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_weight(input logic [IDX_W-1:0] idx, input logic [WGT_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mostly consistent pairs, some random and some out of range
	task automatic random_pair;
		logic [CNT_W-1:0] nb, sa, sb, n11, n00, lim;
		int kind;
		kind = $urandom_range(99);
		if (kind < 10) begin
			send_pair(CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom),
				CNT_W'($urandom), CNT_W'($urandom));
		end else begin
			nb  = (kind < 20) ? CNT_W'($urandom_range(MAX_BITS)) :
				CNT_W'($urandom_range(64, 1));
			if (kind >= 95) nb = CNT_W'(MAX_BITS);
			sa  = CNT_W'($urandom_range(nb));
			sb  = CNT_W'($urandom_range(nb));
			lim = (sa < sb) ? sa : sb;
			n11 = CNT_W'($urandom_range(lim));
			lim = nb - sa - sb + n11;
			n00 = (sa + sb - n11 > nb) ? CNT_W'(0) : CNT_W'($urandom_range(lim));
			if (kind < 15) begin
				n11 = CNT_W'($urandom_range(nb));
				n00 = CNT_W'($urandom_range(nb));
			end
			send_pair(nb, sa, sb, n00, n11);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, bad counts, identical, all clear, saturation
		send_pair(0, 0, 0, 0, 0);
		send_pair(CNT_W'(MAX_BITS), CNT_W'(MAX_BITS), CNT_W'(MAX_BITS), 0, CNT_W'(MAX_BITS));
		send_pair(CNT_W'(MAX_BITS), 0, 0, CNT_W'(MAX_BITS), 0);
		send_pair(CNT_W'(MAX_BITS + 1), 0, 0, 0, 0);
		send_pair(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
		send_pair(8, 9, 0, 0, 0);
		send_pair(8, 0, 9, 0, 0);
		send_pair(8, 0, 0, 9, 0);
		send_pair(8, 0, 0, 0, 9);
		send_pair(CNT_W'(MAX_BITS), 2048, 2048, 1024, 1024);
		send_pair(CNT_W'(MAX_BITS), 4095, 4095, 0, 4094);
		send_pair(10, 5, 5, 0, 0);
		send_pair(10, 3, 4, 4, 1);
		send_pair(2, 1, 1, 1, 0);
		send_pair(8, 8, 0, 0, 0);
		settle();

		// weights: zero sum, extremes, unused index
		write_weight(REG_ON_WEIGHT, 0);
		write_weight(REG_OFF_WEIGHT, 0);
		write_weight(2'd3, 12'hFFF);
		send_pair(10, 3, 4, 4, 1);
		send_pair(10, 3, 3, 3, 3);
		settle();
		write_weight(REG_ON_WEIGHT, 12'hFFF);
		send_pair(10, 3, 4, 4, 1);
		send_pair(100, 90, 90, 2, 80);
		settle();
		write_weight(REG_OFF_WEIGHT, 12'hFFF);
		send_pair(10, 9, 9, 0, 8);
		send_pair(10, 1, 1, 8, 0);
		settle();

		// random phases across weight settings and idle rates
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 56;
				2: idle_pct = 0;
				default: idle_pct = 35;
			endcase
			if (ph == 7) begin
				write_weight(REG_ON_WEIGHT, ON_WEIGHT_RST);
				write_weight(REG_OFF_WEIGHT, OFF_WEIGHT_RST);
			end else begin
				write_weight(REG_ON_WEIGHT, WGT_W'($urandom));
				write_weight(REG_OFF_WEIGHT, (ph == 3) ? 12'd0 : WGT_W'($urandom));
			end
			repeat (50) random_pair();
			settle();
		end

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
